// ----- rtl/smie_pkg.sv -----
// shared types and constants of the stack machine instruction executor
// used by smie_ctrl, smie_dp and the top level; no dependencies
`default_nettype none
package smie_pkg;

  localparam int ADDR_W = 16;
  localparam int FRAME_WORDS = 3;

  typedef enum logic [3:0] {
    OPC_LOAD   = 4'd0,
    OPC_LOADA  = 4'd1,
    OPC_LOADI  = 4'd2,
    OPC_LOADL  = 4'd3,
    OPC_STORE  = 4'd4,
    OPC_STOREI = 4'd5,
    OPC_CALL   = 4'd6,
    OPC_CALLI  = 4'd7,
    OPC_RETURN = 4'd8,
    OPC_UNUSED = 4'd9,
    OPC_PUSH   = 4'd10,
    OPC_POP    = 4'd11,
    OPC_JUMP   = 4'd12,
    OPC_JUMPI  = 4'd13,
    OPC_JUMPIF = 4'd14,
    OPC_HALT   = 4'd15
  } opcode_t;

  localparam logic [3:0] REG_CB = 4'd0;
  localparam logic [3:0] REG_CT = 4'd1;
  localparam logic [3:0] REG_PB = 4'd2;
  localparam logic [3:0] REG_PT = 4'd3;
  localparam logic [3:0] REG_SB = 4'd4;
  localparam logic [3:0] REG_ST = 4'd5;
  localparam logic [3:0] REG_HB = 4'd6;
  localparam logic [3:0] REG_HT = 4'd7;
  localparam logic [3:0] REG_LB = 4'd8;
  localparam logic [3:0] REG_CP = 4'd15;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_OVER  = 3'd1,
    STAT_UNDER = 3'd2,
    STAT_DATA  = 3'd3,
    STAT_CODE  = 3'd4,
    STAT_BADOP = 3'd5,
    STAT_PRIM  = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_POP1,
    OP_POPN,
    OP_DROP,
    OP_RETMIN,
    OP_VA_RD,
    OP_VB_RD,
    OP_WALK_START,
    OP_WALK_READ,
    OP_WALK_NEXT,
    OP_VA_WALK,
    OP_VB_WALK,
    OP_LOAD_READ,
    OP_LOAD_WRITE,
    OP_STORE_READ,
    OP_STORE_WRITE,
    OP_MOVE_READ,
    OP_MOVE_WRITE,
    OP_PUSH,
    OP_ENTER,
    OP_RD_LB1,
    OP_RD_LB2,
    OP_RET_DONE,
    OP_JUMP,
    OP_PUSHST
  } dp_op_t;

  typedef enum logic [1:0] {
    VAL_DRAW,
    VAL_VA,
    VAL_VB,
    VAL_LB
  } val_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     walk_n;
    val_sel_t push_sel;
    logic     fin;
    status_t  fin_status;
    logic     fin_halt;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    stopped;
    logic    fetch_bad;
    logic    prim;
    logic    st_zero;
    logic    st_full;
    logic    popn_under;
    logic    drop_under;
    logic    wcnt_zero;
    logic    i_done;
    logic    load_bad;
    logic    store_bad;
    logic    va_code_bad;
    logic    vb_code_bad;
    logic    va_eq_n;
    logic    nt_neg;
    logic    nt_over;
    logic    clr_last;
  } flags_t;

endpackage
`default_nettype wire

// ----- rtl/stack_machine_instruction_executor_core.sv -----
// top level of the stack machine instruction executor: controller plus datapath
// depends on smie_pkg, smie_ctrl and smie_dp; after reset busy stays high while the data store is cleared
// done rises after start once the controller has followed every static link, made every single-word pop,
// loaded, stored or moved every word and sequenced the rest
// the next start is taken in the done cycle; one instruction per transfer
// the receiver cannot stall: each result is shown for the one cycle that done is high
`default_nettype none
module stack_machine_instruction_executor_core #(
  parameter int MAX_ADDR = 65535,
  parameter int PRIMITIVE_SLOTS = 29
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         opcode,
  input  wire logic [3:0]         reg_index,
  input  wire logic [7:0]         count,
  input  wire logic signed [15:0] displacement,
  input  wire logic               cfg_write,
  input  wire logic [15:0]        cfg_data,
  output logic                    done,
  output logic [15:0]             next_address,
  output logic                    halted,
  output logic [2:0]              status,
  output logic [15:0]             stack_depth
);

  smie_pkg::cmd_t   cmd;
  smie_pkg::flags_t flags;

  smie_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy)
  );

  smie_dp #(
    .MAX_ADDR        (MAX_ADDR),
    .PRIMITIVE_SLOTS (PRIMITIVE_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .flags        (flags),
    .opcode       (opcode),
    .reg_index    (reg_index),
    .count        (count),
    .displacement (displacement),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .next_address (next_address),
    .halted       (halted),
    .status       (status),
    .stack_depth  (stack_depth)
  );

endmodule
`default_nettype wire

// ----- rtl/smie_dp.sv -----
// datapath: data store, machine registers, address and word counters
// depends on smie_pkg; driven by commands from smie_ctrl
`default_nettype none
module smie_dp #(
  parameter int MAX_ADDR = 65535,
  parameter int PRIMITIVE_SLOTS = 29
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire smie_pkg::cmd_t       cmd,
  output smie_pkg::flags_t          flags,
  input  wire logic [3:0]           opcode,
  input  wire logic [3:0]           reg_index,
  input  wire logic [7:0]           count,
  input  wire logic signed [15:0]   displacement,
  input  wire logic                 cfg_write,
  input  wire logic [15:0]          cfg_data,
  output logic                      done,
  output logic [15:0]               next_address,
  output logic                      halted,
  output logic [2:0]                status,
  output logic [15:0]               stack_depth
);

  localparam logic [15:0] MAX_A  = 16'(MAX_ADDR);
  localparam logic [15:0] PRIM_S = 16'(PRIMITIVE_SLOTS);
  localparam int DEPTH = 1 << smie_pkg::ADDR_W;

  logic [15:0] mem [0:DEPTH-1];
  logic [15:0] rd;
  logic [15:0] st, lb, cp, code_top, clr;
  logic        stopped;
  smie_pkg::opcode_t op_q;
  logic [3:0]  r_q;
  logic [7:0]  n_q;
  logic [15:0] d_q;
  logic        fetch_bad;
  logic [15:0] va, vb, wv, src, dst;
  logic [2:0]  wcnt;
  logic [7:0]  i;
  smie_pkg::status_t status_q;

  logic        we;
  logic [15:0] waddr, wdata, raddr;
  logic [15:0] addr_i, src_i, dst_i, push_val, walk_base;
  logic [3:0]  walk_idx;
  logic [2:0]  walk_cnt;
  logic [17:0] nt;
  logic        err;

  assign addr_i = va + {8'd0, i};
  assign src_i  = src + {8'd0, i};
  assign dst_i  = dst + {8'd0, i};
  assign nt     = {2'b00, st} + {{2{d_q[15]}}, d_q};
  assign walk_idx = cmd.walk_n ? n_q[3:0] : r_q;
  assign err = cmd.fin_status != smie_pkg::STAT_OK && cmd.fin_status != smie_pkg::STAT_PRIM;

  always_comb begin
    walk_cnt = 3'd0;
    case (walk_idx)
      smie_pkg::REG_CB, smie_pkg::REG_SB: walk_base = 16'd0;
      smie_pkg::REG_CT, smie_pkg::REG_PB: walk_base = code_top;
      smie_pkg::REG_PT: walk_base = code_top + PRIM_S;
      smie_pkg::REG_ST: walk_base = st;
      smie_pkg::REG_HB, smie_pkg::REG_HT: walk_base = MAX_A;
      smie_pkg::REG_LB: walk_base = lb;
      smie_pkg::REG_CP: walk_base = cp;
      default: begin
        walk_base = lb;
        walk_cnt = 3'(walk_idx - smie_pkg::REG_LB);
      end
    endcase
  end

  always_comb begin
    case (cmd.push_sel)
      smie_pkg::VAL_VA: push_val = va;
      smie_pkg::VAL_VB: push_val = vb;
      smie_pkg::VAL_LB: push_val = lb;
      default:          push_val = d_q;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = st;
    wdata = rd;
    raddr = st - 16'd1;
    case (cmd.op)
      smie_pkg::OP_CLEAR: begin
        we = 1'b1;
        waddr = clr;
        wdata = 16'd0;
      end
      smie_pkg::OP_WALK_READ:  raddr = wv;
      smie_pkg::OP_LOAD_READ:  raddr = addr_i;
      smie_pkg::OP_LOAD_WRITE: we = 1'b1;
      smie_pkg::OP_STORE_READ, smie_pkg::OP_MOVE_READ: raddr = src_i;
      smie_pkg::OP_STORE_WRITE: begin
        we = 1'b1;
        waddr = addr_i;
      end
      smie_pkg::OP_MOVE_WRITE: begin
        we = 1'b1;
        waddr = dst_i;
      end
      smie_pkg::OP_PUSH: begin
        we = 1'b1;
        wdata = push_val;
      end
      smie_pkg::OP_ENTER: begin
        we = 1'b1;
        wdata = cp;
      end
      smie_pkg::OP_RD_LB1: raddr = lb + 16'd1;
      smie_pkg::OP_RD_LB2: raddr = lb + 16'd2;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  // control and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      lb <= '0;
      cp <= '0;
      stopped <= 1'b0;
      code_top <= '0;
      clr <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cfg_write) begin
        code_top <= cfg_data;
      end
      if (cmd.fin) begin
        stopped <= stopped | cmd.fin_halt | err;
      end
      case (cmd.op)
        smie_pkg::OP_CLEAR:  clr <= clr + 16'd1;
        smie_pkg::OP_ACCEPT: if (!stopped) cp <= cp + 16'd1;
        smie_pkg::OP_POP1:   st <= st - 16'd1;
        smie_pkg::OP_POPN:   st <= flags.popn_under ? 16'd0 : st - {8'd0, n_q};
        smie_pkg::OP_DROP: begin
          if (flags.drop_under) begin
            st <= 16'd0;
          end else if (!d_q[15] && d_q != 16'd0) begin
            st <= st - d_q;
          end
        end
        smie_pkg::OP_RETMIN: if (st > lb) st <= lb;
        smie_pkg::OP_LOAD_WRITE, smie_pkg::OP_MOVE_WRITE, smie_pkg::OP_PUSH: st <= st + 16'd1;
        smie_pkg::OP_ENTER: begin
          st <= st + 16'd1;
          lb <= st + 16'd1 - 16'(smie_pkg::FRAME_WORDS);
          cp <= va;
        end
        smie_pkg::OP_RET_DONE: begin
          lb <= va;
          cp <= vb;
        end
        smie_pkg::OP_JUMP:   cp <= va;
        smie_pkg::OP_PUSHST: st <= nt[15:0];
        default: ;
      endcase
    end
  end

  // instruction fields and working registers
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status_q <= cmd.fin_status;
    end
    case (cmd.op)
      smie_pkg::OP_ACCEPT: begin
        op_q <= smie_pkg::opcode_t'(opcode);
        r_q <= reg_index;
        n_q <= count;
        d_q <= displacement;
        fetch_bad <= cp >= code_top;
      end
      smie_pkg::OP_POPN: begin
        src <= flags.popn_under ? 16'd0 : st - {8'd0, n_q};
        i <= '0;
      end
      smie_pkg::OP_DROP: begin
        if (flags.drop_under) begin
          dst <= 16'd0;
        end else if (!d_q[15] && d_q != 16'd0) begin
          dst <= st - d_q;
        end else begin
          dst <= st;
        end
        i <= '0;
      end
      smie_pkg::OP_VA_RD, smie_pkg::OP_RD_LB2: begin
        va <= rd;
        i <= '0;
      end
      smie_pkg::OP_VB_RD: vb <= rd;
      smie_pkg::OP_WALK_START: begin
        wv <= walk_base;
        wcnt <= walk_cnt;
      end
      smie_pkg::OP_WALK_READ: wcnt <= wcnt - 3'd1;
      smie_pkg::OP_WALK_NEXT: wv <= rd;
      smie_pkg::OP_VA_WALK: begin
        va <= wv + d_q;
        i <= '0;
      end
      smie_pkg::OP_VB_WALK: vb <= wv;
      smie_pkg::OP_LOAD_WRITE, smie_pkg::OP_STORE_WRITE, smie_pkg::OP_MOVE_WRITE: i <= i + 8'd1;
      default: ;
    endcase
  end

  always_comb begin
    flags.op          = op_q;
    flags.stopped     = stopped;
    flags.fetch_bad   = fetch_bad;
    flags.prim        = r_q == smie_pkg::REG_PB && !d_q[15] && d_q != 16'd0 && d_q < PRIM_S;
    flags.st_zero     = st == 16'd0;
    flags.st_full     = st >= MAX_A;
    flags.popn_under  = st < {8'd0, n_q};
    flags.drop_under  = !d_q[15] && d_q != 16'd0 && st < d_q;
    flags.wcnt_zero   = wcnt == 3'd0;
    flags.i_done      = i == n_q;
    flags.load_bad    = addr_i >= st || addr_i > MAX_A;
    flags.store_bad   = addr_i >= st || addr_i > MAX_A;
    flags.va_code_bad = va >= code_top;
    flags.vb_code_bad = vb >= code_top;
    flags.va_eq_n     = va == {8'd0, n_q};
    flags.nt_neg      = nt[17];
    flags.nt_over     = !nt[17] && nt[16:0] >= {1'b0, MAX_A};
    flags.clr_last    = clr == 16'(DEPTH - 1);
  end

  assign next_address = cp;
  assign halted       = stopped;
  assign status       = status_q;
  assign stack_depth  = st;

  a_st_bound: assert property (@(posedge clk) disable iff (rst) st <= MAX_A)
    else $error("stack top beyond data store limit");
  a_stopped_hold: assert property (@(posedge clk) disable iff (rst)
    stopped && $past(stopped) |-> $stable(cp) && $stable(st))
    else $error("machine state moved while stopped");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

// ----- rtl/smie_ctrl.sv -----
// controller: sequences each instruction as datapath commands
// depends on smie_pkg; reads status flags from smie_dp
`default_nettype none
module smie_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire smie_pkg::flags_t flags,
  output smie_pkg::cmd_t        cmd,
  output logic                  busy
);

  typedef enum logic [27:0] {
    S_CLEAR      = 28'h0000001,
    S_IDLE       = 28'h0000002,
    S_DECODE     = 28'h0000004,
    S_WALK       = 28'h0000008,
    S_WALK_WAIT  = 28'h0000010,
    S_POP_A      = 28'h0000020,
    S_POP_A_WAIT = 28'h0000040,
    S_POP_B      = 28'h0000080,
    S_POP_B_WAIT = 28'h0000100,
    S_CMP        = 28'h0000200,
    S_JUMP       = 28'h0000400,
    S_LOAD       = 28'h0000800,
    S_LOAD_WR    = 28'h0001000,
    S_STORE      = 28'h0002000,
    S_STORE_WR   = 28'h0004000,
    S_POPN       = 28'h0008000,
    S_DROP       = 28'h0010000,
    S_MOVE       = 28'h0020000,
    S_MOVE_WR    = 28'h0040000,
    S_RET_RD1    = 28'h0080000,
    S_RET_RD2    = 28'h0100000,
    S_RET_RA     = 28'h0200000,
    S_RET_CHK    = 28'h0400000,
    S_PUSH_VA    = 28'h0800000,
    S_CALL_CHK   = 28'h1000000,
    S_PUSH_VB    = 28'h2000000,
    S_PUSH_LB    = 28'h4000000,
    S_ENTER      = 28'h8000000
  } state_t;

  state_t state, state_next;
  logic   walk2, walk2_next;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    walk2_next = walk2;
    cmd.op = smie_pkg::OP_NONE;
    cmd.walk_n = 1'b0;
    cmd.push_sel = smie_pkg::VAL_DRAW;
    cmd.fin = 1'b0;
    cmd.fin_status = smie_pkg::STAT_OK;
    cmd.fin_halt = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = smie_pkg::OP_CLEAR;
        if (flags.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = smie_pkg::OP_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        walk2_next = 1'b0;
        state_next = S_IDLE;
        if (flags.stopped) begin
          cmd.fin = 1'b1;
        end else if (flags.fetch_bad) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_CODE;
        end else begin
          case (flags.op)
            smie_pkg::OPC_LOAD, smie_pkg::OPC_LOADA, smie_pkg::OPC_JUMP: begin
              cmd.op = smie_pkg::OP_WALK_START;
              state_next = S_WALK;
            end
            smie_pkg::OPC_CALL: begin
              if (flags.prim) begin
                cmd.fin = 1'b1;
                cmd.fin_status = smie_pkg::STAT_PRIM;
              end else begin
                cmd.op = smie_pkg::OP_WALK_START;
                state_next = S_WALK;
              end
            end
            smie_pkg::OPC_LOADI, smie_pkg::OPC_STOREI, smie_pkg::OPC_CALLI,
            smie_pkg::OPC_JUMPI, smie_pkg::OPC_JUMPIF: state_next = S_POP_A;
            smie_pkg::OPC_STORE, smie_pkg::OPC_POP, smie_pkg::OPC_RETURN: state_next = S_POPN;
            smie_pkg::OPC_LOADL: begin
              cmd.fin = 1'b1;
              if (flags.st_full) begin
                cmd.fin_status = smie_pkg::STAT_OVER;
              end else begin
                cmd.op = smie_pkg::OP_PUSH;
              end
            end
            smie_pkg::OPC_PUSH: begin
              cmd.fin = 1'b1;
              if (flags.nt_neg) begin
                cmd.fin_status = smie_pkg::STAT_UNDER;
              end else if (flags.nt_over) begin
                cmd.fin_status = smie_pkg::STAT_OVER;
              end else begin
                cmd.op = smie_pkg::OP_PUSHST;
              end
            end
            smie_pkg::OPC_HALT: begin
              cmd.fin = 1'b1;
              cmd.fin_halt = 1'b1;
            end
            default: begin
              cmd.fin = 1'b1;
              cmd.fin_status = smie_pkg::STAT_BADOP;
            end
          endcase
        end
      end
      S_WALK: begin
        if (!flags.wcnt_zero) begin
          cmd.op = smie_pkg::OP_WALK_READ;
          state_next = S_WALK_WAIT;
        end else begin
          cmd.op = smie_pkg::OP_VA_WALK;
          case (flags.op)
            smie_pkg::OPC_LOAD:  state_next = S_LOAD;
            smie_pkg::OPC_LOADA: state_next = S_PUSH_VA;
            smie_pkg::OPC_STORE: state_next = S_STORE;
            smie_pkg::OPC_CALL: begin
              if (walk2) begin
                cmd.op = smie_pkg::OP_VB_WALK;
                state_next = S_PUSH_VB;
              end else begin
                state_next = S_CALL_CHK;
              end
            end
            smie_pkg::OPC_JUMP, smie_pkg::OPC_JUMPIF: state_next = S_JUMP;
            default: begin
              cmd.fin = 1'b1;
              cmd.fin_status = smie_pkg::STAT_BADOP;
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_WALK_WAIT: begin
        cmd.op = smie_pkg::OP_WALK_NEXT;
        state_next = S_WALK;
      end
      S_POP_A, S_POP_B: begin
        if (flags.st_zero) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_UNDER;
          state_next = S_IDLE;
        end else begin
          cmd.op = smie_pkg::OP_POP1;
          state_next = (state == S_POP_A) ? S_POP_A_WAIT : S_POP_B_WAIT;
        end
      end
      S_POP_A_WAIT: begin
        cmd.op = smie_pkg::OP_VA_RD;
        case (flags.op)
          smie_pkg::OPC_LOADI:  state_next = S_LOAD;
          smie_pkg::OPC_STOREI: state_next = S_POPN;
          smie_pkg::OPC_CALLI:  state_next = S_POP_B;
          smie_pkg::OPC_JUMPI:  state_next = S_JUMP;
          default:              state_next = S_CMP;
        endcase
      end
      S_POP_B_WAIT: begin
        cmd.op = smie_pkg::OP_VB_RD;
        state_next = S_CALL_CHK;
      end
      S_CMP: begin
        if (flags.va_eq_n) begin
          cmd.op = smie_pkg::OP_WALK_START;
          state_next = S_WALK;
        end else begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_JUMP: begin
        cmd.fin = 1'b1;
        state_next = S_IDLE;
        if (flags.va_code_bad) begin
          cmd.fin_status = smie_pkg::STAT_CODE;
        end else begin
          cmd.op = smie_pkg::OP_JUMP;
        end
      end
      S_LOAD: begin
        if (flags.i_done) begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end else if (flags.load_bad) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_DATA;
          state_next = S_IDLE;
        end else if (flags.st_full) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_OVER;
          state_next = S_IDLE;
        end else begin
          cmd.op = smie_pkg::OP_LOAD_READ;
          state_next = S_LOAD_WR;
        end
      end
      S_LOAD_WR: begin
        cmd.op = smie_pkg::OP_LOAD_WRITE;
        state_next = S_LOAD;
      end
      S_STORE: begin
        if (flags.i_done) begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end else if (flags.store_bad) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_DATA;
          state_next = S_IDLE;
        end else begin
          cmd.op = smie_pkg::OP_STORE_READ;
          state_next = S_STORE_WR;
        end
      end
      S_STORE_WR: begin
        cmd.op = smie_pkg::OP_STORE_WRITE;
        state_next = S_STORE;
      end
      S_POPN: begin
        cmd.op = smie_pkg::OP_POPN;
        if (flags.popn_under) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_UNDER;
          state_next = S_IDLE;
        end else begin
          case (flags.op)
            smie_pkg::OPC_STORE:  state_next = S_CMP;
            smie_pkg::OPC_STOREI: state_next = S_STORE;
            smie_pkg::OPC_POP:    state_next = S_DROP;
            default:              state_next = S_RET_RD1;
          endcase
          // store: start the base register walk once the stack top has settled
          if (flags.op == smie_pkg::OPC_STORE) state_next = S_PUSH_VA;
        end
      end
      S_DROP: begin
        cmd.op = smie_pkg::OP_DROP;
        if (flags.drop_under) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_UNDER;
          state_next = S_IDLE;
        end else begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        if (flags.i_done) begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
          if (flags.op == smie_pkg::OPC_RETURN) cmd.op = smie_pkg::OP_RET_DONE;
        end else begin
          cmd.op = smie_pkg::OP_MOVE_READ;
          state_next = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        cmd.op = smie_pkg::OP_MOVE_WRITE;
        state_next = S_MOVE;
      end
      S_RET_RD1: begin
        cmd.op = smie_pkg::OP_RD_LB1;
        state_next = S_RET_RD2;
      end
      S_RET_RD2: begin
        cmd.op = smie_pkg::OP_RD_LB2;
        state_next = S_RET_RA;
      end
      S_RET_RA: begin
        cmd.op = smie_pkg::OP_VB_RD;
        state_next = S_RET_CHK;
      end
      S_RET_CHK: begin
        if (flags.vb_code_bad) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_CODE;
          state_next = S_IDLE;
        end else begin
          cmd.op = smie_pkg::OP_RETMIN;
          state_next = S_DROP;
        end
      end
      S_PUSH_VA: begin
        if (flags.op == smie_pkg::OPC_STORE) begin
          cmd.op = smie_pkg::OP_WALK_START;
          state_next = S_WALK;
        end else begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
          if (flags.st_full) begin
            cmd.fin_status = smie_pkg::STAT_OVER;
          end else begin
            cmd.op = smie_pkg::OP_PUSH;
            cmd.push_sel = smie_pkg::VAL_VA;
          end
        end
      end
      S_CALL_CHK: begin
        if (flags.va_code_bad) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_CODE;
          state_next = S_IDLE;
        end else if (flags.op == smie_pkg::OPC_CALL) begin
          cmd.op = smie_pkg::OP_WALK_START;
          cmd.walk_n = 1'b1;
          walk2_next = 1'b1;
          state_next = S_WALK;
        end else begin
          state_next = S_PUSH_VB;
        end
      end
      S_PUSH_VB, S_PUSH_LB: begin
        if (flags.st_full) begin
          cmd.fin = 1'b1;
          cmd.fin_status = smie_pkg::STAT_OVER;
          state_next = S_IDLE;
        end else begin
          cmd.op = smie_pkg::OP_PUSH;
          cmd.push_sel = (state == S_PUSH_VB) ? smie_pkg::VAL_VB : smie_pkg::VAL_LB;
          state_next = (state == S_PUSH_VB) ? S_PUSH_LB : S_ENTER;
        end
      end
      S_ENTER: begin
        cmd.fin = 1'b1;
        state_next = S_IDLE;
        if (flags.st_full) begin
          cmd.fin_status = smie_pkg::STAT_OVER;
        end else begin
          cmd.op = smie_pkg::OP_ENTER;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      walk2 <= 1'b0;
    end else begin
      state <= state_next;
      walk2 <= walk2_next;
    end
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (rst) cmd.fin |=> state == S_IDLE)
    else $error("instruction finished without returning to idle");
  a_clear_no_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> cmd.op == smie_pkg::OP_CLEAR && !cmd.fin)
    else $error("activity during store clearing");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && start |=> state == S_DECODE)
    else $error("accepted instruction not decoded");

endmodule
`default_nettype wire

// ----- tb/sv/stack_machine_instruction_executor_core_tb.sv -----
// testbench of stack_machine_instruction_executor_core: queue-fed driver, clocked monitor
// and an instruction-level predictor of the machine state; depends on smie_pkg and the rtl
`timescale 1ns / 100ps
`default_nettype none
module stack_machine_instruction_executor_core_tb;

  localparam int MAX_ADDR = 65535;
  localparam int PRIM_SLOTS = 29;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [3:0] REG_L1 = 4'd9;
  localparam logic [3:0] REG_L6 = 4'd14;

  typedef struct {
    logic [3:0]  opc;
    logic [3:0]  rsel;
    logic [7:0]  cnt;
    logic [15:0] disp;
  } instr_t;

  typedef struct {
    logic [15:0] na;
    logic        hlt;
    logic [2:0]  stat;
    logic [15:0] sd;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] opcode = '0;
  logic [3:0] reg_index = '0;
  logic [7:0] count = '0;
  logic signed [15:0] displacement = '0;
  logic cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  wire logic busy, done, halted;
  wire logic [15:0] next_address, stack_depth;
  wire logic [2:0] status;

  stack_machine_instruction_executor_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .reg_index(reg_index), .count(count), .displacement(displacement),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
    .next_address(next_address), .halted(halted), .status(status),
    .stack_depth(stack_depth)
  );

  always #5 clk = ~clk;

  // machine state as predicted
  logic [15:0] mem [0:65535];
  int unsigned st, lb, cp, ctop;
  bit stopped;
  logic [15:0] blk [0:255];
  logic [15:0] undo_addr [$];
  logic [15:0] undo_val [$];

  instr_t pending_instrs [$];
  outcome_t expected_results [$];
  int mismatches = 0;
  int cycles = 0;

  function automatic void mem_wr(input logic [15:0] a, input logic [15:0] v);
    undo_addr = {undo_addr, a};
    undo_val = {undo_val, mem[a]};
    mem[a] = v;
  endfunction

  function automatic int unsigned reg_val(input logic [3:0] r);
    int unsigned v;
    int k;
    case (r)
      smie_pkg::REG_CT, smie_pkg::REG_PB: return ctop;
      smie_pkg::REG_PT: return (ctop + PRIM_SLOTS) & 16'hffff;
      smie_pkg::REG_ST: return st;
      smie_pkg::REG_HB, smie_pkg::REG_HT: return MAX_ADDR;
      smie_pkg::REG_LB: return lb;
      smie_pkg::REG_CP: return cp;
      smie_pkg::REG_CB, smie_pkg::REG_SB: return 0;
      default: begin
        v = lb;
        for (k = 8; k < r; k++) v = mem[v[15:0]];
        return v;
      end
    endcase
  endfunction

  function automatic int push_w(input int unsigned v);
    if (st >= MAX_ADDR) return 1;
    mem_wr(st[15:0], v[15:0]);
    st = (st + 1) & 16'hffff;
    return 0;
  endfunction

  function automatic int pop_w(output int unsigned v);
    v = 0;
    if (st == 0) return 2;
    st = st - 1;
    v = mem[st[15:0]];
    return 0;
  endfunction

  function automatic bit addr_bad(input int unsigned a);
    return a >= st && a <= MAX_ADDR;
  endfunction

  function automatic int pop_blk(input int unsigned n);
    int unsigned v;
    for (int unsigned i = 0; i < n; i++) begin
      if (pop_w(v) != 0) return 2;
      blk[n - 1 - i] = v[15:0];
    end
    return 0;
  endfunction

  function automatic int push_blk(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (push_w(blk[i]) != 0) return 1;
    return 0;
  endfunction

  function automatic int drop_w(input int d);
    if (d <= 0) return 0;
    if (st < d) begin
      st = 0;
      return 2;
    end
    st = st - d;
    return 0;
  endfunction

  function automatic int load_w(input int unsigned base, input int unsigned n);
    int unsigned a;
    for (int unsigned i = 0; i < n; i++) begin
      a = (base + i) & 16'hffff;
      if (addr_bad(a)) return 3;
      if (push_w(mem[a[15:0]]) != 0) return 1;
    end
    return 0;
  endfunction

  function automatic int store_w(input int unsigned base, input int unsigned n);
    int unsigned a;
    for (int unsigned i = 0; i < n; i++) begin
      a = (base + i) & 16'hffff;
      if (addr_bad(a)) return 3;
      mem_wr(a[15:0], blk[i]);
    end
    return 0;
  endfunction

  function automatic int enter_frame(input int unsigned link, input int unsigned tgt);
    if (push_w(link) != 0) return 1;
    if (push_w(lb) != 0) return 1;
    if (push_w(cp) != 0) return 1;
    lb = (st - smie_pkg::FRAME_WORDS) & 16'hffff;
    cp = tgt & 16'hffff;
    return 0;
  endfunction

  function automatic int jump_to(input int unsigned t);
    if (t >= ctop) return smie_pkg::STAT_CODE;
    cp = t;
    return 0;
  endfunction

  function automatic outcome_t exec_instr(input instr_t it);
    outcome_t o;
    int unsigned n, draw, pc, a, b, dl, ra;
    int d, nt, s;
    smie_pkg::opcode_t op;
    op = smie_pkg::opcode_t'(it.opc);
    n = it.cnt;
    draw = it.disp;
    d = $signed(it.disp);
    a = 0;
    b = 0;
    s = 0;
    if (!stopped) begin
      pc = cp;
      cp = (cp + 1) & 16'hffff;
      if (pc >= ctop) s = smie_pkg::STAT_CODE;
      else begin
        case (op)
          smie_pkg::OPC_LOAD: s = load_w(reg_val(it.rsel) + draw, n);
          smie_pkg::OPC_LOADA: s = push_w(reg_val(it.rsel) + draw);
          smie_pkg::OPC_LOADI: begin
            s = pop_w(a);
            if (s == 0) s = load_w(a, n);
          end
          smie_pkg::OPC_LOADL: s = push_w(draw);
          smie_pkg::OPC_STORE: begin
            s = pop_blk(n);
            if (s == 0) s = store_w(reg_val(it.rsel) + draw, n);
          end
          smie_pkg::OPC_STOREI: begin
            s = pop_w(a);
            if (s == 0) s = pop_blk(n);
            if (s == 0) s = store_w(a, n);
          end
          smie_pkg::OPC_CALL: begin
            if (it.rsel == smie_pkg::REG_PB && d > 0 && d < PRIM_SLOTS) begin
              s = smie_pkg::STAT_PRIM;
            end else begin
              a = (reg_val(it.rsel) + draw) & 16'hffff;
              if (a >= ctop) s = smie_pkg::STAT_CODE;
              else s = enter_frame(reg_val(it.cnt[3:0]), a);
            end
          end
          smie_pkg::OPC_CALLI: begin
            s = pop_w(a);
            if (s == 0) s = pop_w(b);
            if (s == 0 && a >= ctop) s = smie_pkg::STAT_CODE;
            if (s == 0) s = enter_frame(b, a);
          end
          smie_pkg::OPC_RETURN: begin
            s = pop_blk(n);
            if (s == 0) begin
              dl = mem[(lb + 1) & 16'hffff];
              ra = mem[(lb + 2) & 16'hffff];
              if (ra >= ctop) s = smie_pkg::STAT_CODE;
              else begin
                if (st > lb) st = lb;
                s = drop_w(d);
                if (s == 0) s = push_blk(n);
                if (s == 0) begin
                  lb = dl;
                  cp = ra;
                end
              end
            end
          end
          smie_pkg::OPC_PUSH: begin
            nt = int'(st) + d;
            if (nt < 0) s = smie_pkg::STAT_UNDER;
            else if (nt >= MAX_ADDR) s = smie_pkg::STAT_OVER;
            else st = nt;
          end
          smie_pkg::OPC_POP: begin
            s = pop_blk(n);
            if (s == 0) s = drop_w(d);
            if (s == 0) s = push_blk(n);
          end
          smie_pkg::OPC_JUMP: s = jump_to((reg_val(it.rsel) + draw) & 16'hffff);
          smie_pkg::OPC_JUMPI: begin
            s = pop_w(a);
            if (s == 0) s = jump_to(a);
          end
          smie_pkg::OPC_JUMPIF: begin
            s = pop_w(a);
            if (s == 0 && a == n) s = jump_to((reg_val(it.rsel) + draw) & 16'hffff);
          end
          smie_pkg::OPC_HALT: stopped = 1'b1;
          default: s = smie_pkg::STAT_BADOP;
        endcase
      end
      if (s != 0 && s != smie_pkg::STAT_PRIM) stopped = 1'b1;
    end
    o.na = cp[15:0];
    o.hlt = stopped;
    o.stat = s[2:0];
    o.sd = st[15:0];
    return o;
  endfunction

  // queue an instruction; with keep_running set, one that would stop the machine is undone
  function automatic bit offer(input instr_t it, input bit keep_running);
    int unsigned s_st, s_lb, s_cp;
    outcome_t o;
    s_st = st;
    s_lb = lb;
    s_cp = cp;
    undo_addr.delete();
    undo_val.delete();
    o = exec_instr(it);
    if (keep_running && stopped) begin
      while (undo_addr.size() > 0) mem[undo_addr.pop_back()] = undo_val.pop_back();
      st = s_st;
      lb = s_lb;
      cp = s_cp;
      stopped = 1'b0;
      return 1'b0;
    end
    pending_instrs = {pending_instrs, it};
    expected_results = {expected_results, o};
    return 1'b1;
  endfunction

  function automatic instr_t mk(input smie_pkg::opcode_t op, input logic [3:0] r,
                                input logic [7:0] n, input logic [15:0] dsp);
    instr_t it;
    it.opc = op;
    it.rsel = r;
    it.cnt = n;
    it.disp = dsp;
    return it;
  endfunction

  function automatic logic [7:0] rand_count();
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [15:0] data_target();
    if (st == 0) return 16'($urandom);
    return 16'($urandom_range(0, st - 1));
  endfunction

  function automatic logic [15:0] code_target();
    if (ctop == 0) return 16'($urandom);
    return 16'($urandom_range(0, ctop - 1));
  endfunction

  // mostly well-formed instructions built from the predicted state, some pure noise
  function automatic void gen_one(input bit keep_running);
    instr_t it;
    logic [3:0] r;
    int pick;
    bit ok;
    ok = 1'b0;
    for (int t = 0; t < 8 && !ok; t++) begin
      r = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (st > 3000) pick = 60;
      if (pick < 10) begin
        it = mk(smie_pkg::OPC_LOAD, r, rand_count(), 16'(data_target() - reg_val(r)));
      end else if (pick < 16) begin
        it = mk(smie_pkg::OPC_LOADA, r, 8'($urandom), 16'($urandom));
      end else if (pick < 24) begin
        it = mk(smie_pkg::OPC_LOADL, r, 8'($urandom), 16'($urandom));
      end else if (pick < 30) begin
        if (offer(mk(smie_pkg::OPC_LOADL, r, 8'($urandom), data_target()), keep_running))
          it = mk(smie_pkg::OPC_LOADI, r, rand_count(), 16'($urandom));
        else it = mk(smie_pkg::OPC_LOADL, r, 8'($urandom), 16'($urandom));
      end else if (pick < 38) begin
        it = mk(smie_pkg::OPC_STORE, r, rand_count(), 16'(data_target() - reg_val(r)));
      end else if (pick < 43) begin
        if (offer(mk(smie_pkg::OPC_LOADL, r, 8'($urandom), data_target()), keep_running))
          it = mk(smie_pkg::OPC_STOREI, r, rand_count(), 16'($urandom));
        else it = mk(smie_pkg::OPC_LOADL, r, 8'($urandom), 16'($urandom));
      end else if (pick < 50) begin
        if ($urandom_range(0, 3) == 0)
          it = mk(smie_pkg::OPC_CALL, smie_pkg::REG_PB, 8'($urandom),
                  16'($urandom_range(0, 40)));
        else it = mk(smie_pkg::OPC_CALL, r, 8'($urandom), 16'(code_target() - reg_val(r)));
      end else if (pick < 54) begin
        ok = offer(mk(smie_pkg::OPC_LOADL, r, 8'($urandom), 16'($urandom)), keep_running);
        ok = offer(mk(smie_pkg::OPC_LOADL, r, 8'($urandom), code_target()), keep_running);
        it = mk(smie_pkg::OPC_CALLI, r, 8'($urandom), 16'($urandom));
      end else if (pick < 60) begin
        it = mk(smie_pkg::OPC_RETURN, r, rand_count(),
                16'($signed($urandom_range(0, 12)) - 2));
      end else if (pick < 68) begin
        it = mk(smie_pkg::OPC_PUSH, r, 8'($urandom),
                16'($signed($urandom_range(0, 60)) - 20));
      end else if (pick < 76) begin
        it = mk(smie_pkg::OPC_POP, r, rand_count(),
                16'($signed($urandom_range(0, st > 40 ? 40 : st)) - 3));
      end else if (pick < 80) begin
        it = mk(smie_pkg::OPC_JUMP, r, 8'($urandom), 16'(code_target() - reg_val(r)));
      end else if (pick < 84) begin
        ok = offer(mk(smie_pkg::OPC_LOADL, r, 8'($urandom), code_target()), keep_running);
        it = mk(smie_pkg::OPC_JUMPI, r, 8'($urandom), 16'($urandom));
      end else if (pick < 92) begin
        it = mk(smie_pkg::OPC_JUMPIF, r, 8'($urandom), 16'(code_target() - reg_val(r)));
        if (st > 0 && $urandom_range(0, 1) == 0) it.cnt = mem[st - 1][7:0];
      end else begin
        it = mk(smie_pkg::opcode_t'($urandom_range(0, 15)), r, 8'($urandom), 16'($urandom));
      end
      ok = offer(it, keep_running);
    end
    if (!ok)
      ok = offer(mk(smie_pkg::OPC_LOADL, smie_pkg::REG_CB, 8'($urandom), 16'($urandom)),
                 keep_running);
  endfunction

  task automatic drain();
    while (pending_instrs.size() > 0 || expected_results.size() > 0 || start)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_code_top(input logic [15:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_data <= 16'($urandom);
    ctop = v;
  endtask

  // driver
  bit took = 1'b0;
  int gap = 0;
  bit no_idle = 1'b0;
  instr_t cur;

  function automatic int next_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    took <= start && !busy;
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if ($urandom_range(0, 39) == 0) no_idle <= ~no_idle;
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_instrs.size() > 0) begin
        cur = pending_instrs.pop_front();
        opcode <= cur.opc;
        reg_index <= cur.rsel;
        count <= cur.cnt;
        displacement <= cur.disp;
        start <= 1'b1;
        gap <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  outcome_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: next_address %h status %0d",
                                       next_address, status);
      end else begin
        want = expected_results.pop_front();
        if (next_address !== want.na || halted !== want.hlt || status !== want.stat ||
            stack_depth !== want.sd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected na %h hlt %b st %0d sd %h, got na %h hlt %b st %0d sd %h",
                     want.na, want.hlt, want.stat, want.sd,
                     next_address, halted, status, stack_depth);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  bit ok;

  initial begin
    for (int i = 0; i < 65536; i++) mem[i] = '0;
    st = 0;
    lb = 0;
    cp = 0;
    ctop = 0;
    stopped = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    set_code_top(16'hffff);

    ok = offer(mk(smie_pkg::OPC_LOADL, smie_pkg::REG_CB, 8'h00, 16'h0000), 1);
    ok = offer(mk(smie_pkg::OPC_LOADL, smie_pkg::REG_CB, 8'hff, 16'h7fff), 1);
    ok = offer(mk(smie_pkg::OPC_LOADL, smie_pkg::REG_CB, 8'h00, 16'h8000), 1);
    ok = offer(mk(smie_pkg::OPC_LOADL, smie_pkg::REG_CB, 8'hff, 16'hffff), 1);
    ok = offer(mk(smie_pkg::OPC_LOADA, smie_pkg::REG_CT, 8'h00, 16'h0001), 1);
    ok = offer(mk(smie_pkg::OPC_LOADA, smie_pkg::REG_PT, 8'h00, 16'hffff), 1);
    ok = offer(mk(smie_pkg::OPC_LOADA, smie_pkg::REG_HB, 8'h00, 16'h8000), 1);
    ok = offer(mk(smie_pkg::OPC_LOADA, smie_pkg::REG_ST, 8'h00, 16'h0000), 1);
    ok = offer(mk(smie_pkg::OPC_LOADA, smie_pkg::REG_CP, 8'h00, 16'h0000), 1);
    ok = offer(mk(smie_pkg::OPC_LOADA, REG_L6, 8'h00, 16'h0000), 1);
    ok = offer(mk(smie_pkg::OPC_PUSH, smie_pkg::REG_CB, 8'h00, 16'd5), 1);
    ok = offer(mk(smie_pkg::OPC_PUSH, smie_pkg::REG_CB, 8'h00, -16'sd2), 1);
    ok = offer(mk(smie_pkg::OPC_POP, smie_pkg::REG_CB, 8'd1, 16'd2), 1);
    ok = offer(mk(smie_pkg::OPC_LOAD, smie_pkg::REG_SB, 8'd2, 16'd0), 1);
    ok = offer(mk(smie_pkg::OPC_STORE, smie_pkg::REG_SB, 8'd1, 16'd0), 1);
    ok = offer(mk(smie_pkg::OPC_CALL, smie_pkg::REG_PB, 8'd0, 16'd1), 1);
    ok = offer(mk(smie_pkg::OPC_CALL, smie_pkg::REG_CB, REG_L1, 16'd40), 1);
    ok = offer(mk(smie_pkg::OPC_RETURN, smie_pkg::REG_CB, 8'd1, 16'd0), 1);
    ok = offer(mk(smie_pkg::OPC_LOADL, smie_pkg::REG_CB, 8'd0, 16'd3), 1);
    ok = offer(mk(smie_pkg::OPC_JUMPIF, smie_pkg::REG_CB, 8'd3, 16'd20), 1);
    ok = offer(mk(smie_pkg::OPC_LOADL, smie_pkg::REG_CB, 8'd0, 16'd3), 1);
    ok = offer(mk(smie_pkg::OPC_JUMPIF, smie_pkg::REG_CB, 8'd5, 16'd30), 1);
    ok = offer(mk(smie_pkg::OPC_LOADL, smie_pkg::REG_CB, 8'd0, 16'd0), 1);
    ok = offer(mk(smie_pkg::OPC_LOADI, smie_pkg::REG_CB, 8'd2, 16'd0), 1);

    for (int i = 0; i < 150; i++) gen_one(1);
    drain();
    for (int i = 0; i < 150; i++) gen_one(1);
    set_code_top(cp < 40000 ? 16'd40000 : 16'hffff);
    for (int i = 0; i < 250; i++) gen_one(1);
    set_code_top(16'(cp + 1 + $urandom_range(600, 20000)));
    for (int i = 0; i < 250; i++) gen_one(1);
    drain();
    for (int i = 0; i < 200 && !stopped; i++) gen_one(0);
    if (!stopped)
      ok = offer(mk(smie_pkg::OPC_HALT, 4'($urandom), 8'($urandom), 16'($urandom)), 0);
    for (int i = 0; i < 10; i++) gen_one(0);
    set_code_top(16'h0000);
    for (int i = 0; i < 10; i++) gen_one(0);
    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
